[hw/rtl/pnv_pkg.sv]
// pnv_pkg: shared constants, register indexes and multiplier port types
// for the pulse/noise voice with adsr envelope; no dependencies

package pnv_pkg;

  // serial multiplier geometry: radix-4, two multiplier bits per step
  localparam int unsigned MUL_AW    = 25;               // parallel operand
  localparam int unsigned MUL_BW    = 26;               // serial operand
  localparam int unsigned MUL_PW    = MUL_AW + MUL_BW;  // full product
  localparam int unsigned MUL_STEPS = MUL_BW / 2;
  localparam int unsigned MUL_CW    = $clog2(MUL_STEPS);

  // fixed-point unity in q1.24, envelope full scale
  localparam logic [24:0] ONE_Q24 = 25'h1000000;

  // build-time voice select: 0 pulse voice, 1 lfsr noise voice
  localparam bit NOISE_VOICE = 1'b0;

  // configuration register indexes
  localparam logic [2:0] REG_ATTACK_LEN    = 3'd0;
  localparam logic [2:0] REG_ATTACK_RATE   = 3'd1;
  localparam logic [2:0] REG_DECAY_LEN     = 3'd2;
  localparam logic [2:0] REG_DECAY_RATE    = 3'd3;
  localparam logic [2:0] REG_SUSTAIN_LEVEL = 3'd4;
  localparam logic [2:0] REG_RELEASE_RATE  = 3'd5;
  localparam logic [2:0] REG_PULSE_DUTY    = 3'd6;
  localparam logic [2:0] REG_OUTPUT_GAIN   = 3'd7;

  // configuration reset values
  localparam logic [19:0] RST_ATTACK_LEN    = 20'd192;
  localparam logic [24:0] RST_ATTACK_RATE   = 25'd87381;
  localparam logic [19:0] RST_DECAY_LEN     = 20'd4800;
  localparam logic [24:0] RST_DECAY_RATE    = 25'd3495;
  localparam logic [15:0] RST_SUSTAIN_LEVEL = 16'd18022;
  localparam logic [24:0] RST_RELEASE_RATE  = 25'd5825;
  localparam logic [16:0] RST_PULSE_DUTY    = 17'd32768;
  localparam logic [16:0] RST_OUTPUT_GAIN   = 17'd14418;

  // multiplier request and response
  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [MUL_PW-1:0] prod;
  } mul_rsp_t;

endpackage

[hw/rtl/pnv_smul.sv]
// pnv_smul: digit-serial unsigned multiplier, two multiplier bits per cycle
// depends on pnv_pkg for operand widths and request/response types

module pnv_smul
  import pnv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [MUL_AW-1:0] a_r;
  logic [MUL_BW-1:0] b_r;
  logic [MUL_AW-1:0] hi_r;
  logic [MUL_BW-1:0] lo_r;
  logic [MUL_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [MUL_AW+1:0] sum;
  logic              last;

  // one radix-4 digit: add a times the two low multiplier bits
  always_comb begin
    sum = {2'b00, hi_r}
        + (b_r[0] ? {2'b00, a_r} : '0)
        + (b_r[1] ? {1'b0, a_r, 1'b0} : '0);
  end

  assign last = (cnt_r == MUL_CW'(MUL_STEPS - 1));

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath: accumulator and product low half shift right by one digit
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r  <= req.a;
      b_r  <= req.b;
      hi_r <= '0;
      lo_r <= '0;
    end else if (busy_r) begin
      b_r  <= {2'b00, b_r[MUL_BW-1:2]};
      hi_r <= sum[MUL_AW+1:2];
      lo_r <= {sum[1:0], lo_r[MUL_BW-1:2]};
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = {hi_r, lo_r};

endmodule

[hw/rtl/pulse_noise_voice_adsr_unit.sv]
// pulse_noise_voice_adsr_unit: one voice, pulse or lfsr noise wave shaped by
// a linear adsr envelope and gain; uses pnv_pkg and pnv_smul
// a note-on transfer gives no result
// a tick runs zero to five multiplies before its result is loaded at out
// multiplies go through the one radix-4 serial multiplier, 13 digit steps each
// one item in flight; the next input
// is taken while a result waits at out
// synchronous active-low reset: config to defaults, age/phase/step/gate 0, lfsr 1

module pulse_noise_voice_adsr_unit
  import pnv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [23:0]        in_phase_step,
  input  logic [19:0]        in_gate_len,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [24:0]        cfg_wdata
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_RCHK = 3'd3;
  localparam logic [2:0] S_GCHK = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // multiply in progress
  localparam logic [2:0] OP_ATK   = 3'd0;
  localparam logic [2:0] OP_DEC_T = 3'd1;
  localparam logic [2:0] OP_DEC_E = 3'd2;
  localparam logic [2:0] OP_REL_R = 3'd3;
  localparam logic [2:0] OP_REL_E = 3'd4;
  localparam logic [2:0] OP_GAIN  = 3'd5;

  localparam logic [20:0] AGE_MAX = 21'h1FFFFF;

  // configuration registers
  logic [19:0] attack_len_r;
  logic [24:0] attack_rate_r;
  logic [19:0] decay_len_r;
  logic [24:0] decay_rate_r;
  logic [15:0] sustain_level_r;
  logic [24:0] release_rate_r;
  logic [16:0] pulse_duty_r;
  logic [16:0] output_gain_r;

  // voice state
  logic [2:0]  state_r, state_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [20:0] note_age_r, note_age_nxt;
  logic [23:0] osc_phase_r, osc_phase_nxt;
  logic [15:0] lfsr_r, lfsr_nxt;
  logic [23:0] held_step_r, held_step_nxt;
  logic [19:0] held_gate_r, held_gate_nxt;
  logic        rel_r, rel_nxt;
  logic        high_r, high_nxt;
  logic [24:0] env_r, env_nxt;
  logic [15:0] res_r, res_nxt;
  logic        mul_start_r, mul_start_nxt;
  logic [24:0] mul_a_r, mul_a_nxt;
  logic [25:0] mul_b_r, mul_b_nxt;
  logic        out_valid_r;
  logic [15:0] out_sample_r;

  mul_req_t    mreq;
  mul_rsp_t    mrsp;

  // derived values
  logic        in_fire;
  logic        out_load;
  logic [20:0] decay_end;
  logic [15:0] sus_sat;
  logic [24:0] sus_q24;
  logic [16:0] gain_sat;
  logic [16:0] duty_sat;
  logic [24:0] p_hi;
  logic [25:0] p_lo;
  logic [24:0] p_sat;
  logic [24:0] p_shr24;
  logic        r_full;
  logic [24:0] one_minus_r;
  logic [15:0] mag;
  logic [24:0] phase_sum;
  logic [15:0] lfsr_step;
  logic        lfsr_fb;

  assign in_ready = rst_n && (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // register saturation and sustain in q1.24
  assign sus_sat   = (sustain_level_r > 16'd32768) ? 16'd32768 : sustain_level_r;
  assign sus_q24   = {sus_sat, 9'b0};
  assign gain_sat  = (output_gain_r > 17'h10000) ? 17'h10000 : output_gain_r;
  assign duty_sat  = (pulse_duty_r > 17'h10000) ? 17'h10000 : pulse_duty_r;
  assign decay_end = {1'b0, attack_len_r} + {1'b0, decay_len_r};

  // product views
  assign p_hi        = mrsp.prod[MUL_PW-1:MUL_BW];
  assign p_lo        = mrsp.prod[MUL_BW-1:0];
  assign p_sat       = ((p_hi != '0) || (p_lo > {1'b0, ONE_Q24})) ? ONE_Q24 : p_lo[24:0];
  assign p_shr24     = {p_hi[22:0], p_lo[25:24]};
  assign r_full      = (p_hi != '0) || (p_lo[25:24] != 2'b00);
  assign one_minus_r = ONE_Q24 - {1'b0, p_lo[23:0]};
  assign mag         = {p_hi[14:0], p_lo[25]};

  // oscillator advance and lfsr shift
  assign phase_sum = {1'b0, osc_phase_r} + {1'b0, held_step_r};
  assign lfsr_fb   = lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5];
  assign lfsr_step = {lfsr_fb, lfsr_r[15:1]};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    note_age_nxt  = note_age_r;
    osc_phase_nxt = osc_phase_r;
    lfsr_nxt      = lfsr_r;
    held_step_nxt = held_step_r;
    held_gate_nxt = held_gate_r;
    rel_nxt       = rel_r;
    high_nxt      = high_r;
    env_nxt       = env_r;
    res_nxt       = res_r;
    mul_start_nxt = 1'b0;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_action) begin
            held_step_nxt = in_phase_step;
            held_gate_nxt = in_gate_len;
            note_age_nxt  = '0;
            osc_phase_nxt = '0;
          end else begin
            if (note_age_r < AGE_MAX) begin
              note_age_nxt = note_age_r + 1'b1;
            end
            state_nxt = S_PREP;
          end
        end
      end

      // pick the envelope segment and note whether release applies
      S_PREP: begin
        rel_nxt = note_age_r > {1'b0, held_gate_r};
        if (note_age_r < {1'b0, attack_len_r}) begin
          mul_start_nxt = 1'b1;
          mul_a_nxt     = attack_rate_r;
          mul_b_nxt     = {5'b0, note_age_r};
          op_nxt        = OP_ATK;
          state_nxt     = S_MUL;
        end else if (note_age_r < decay_end) begin
          mul_start_nxt = 1'b1;
          mul_a_nxt     = decay_rate_r;
          mul_b_nxt     = {5'b0, note_age_r - {1'b0, attack_len_r}};
          op_nxt        = OP_DEC_T;
          state_nxt     = S_MUL;
        end else begin
          env_nxt   = sus_q24;
          state_nxt = S_RCHK;
        end
      end

      // wait for the product, then use it by operation
      S_MUL: begin
        if (mrsp.done) begin
          unique case (op_r)
            OP_ATK: begin
              env_nxt   = p_sat;
              state_nxt = S_RCHK;
            end
            OP_DEC_T: begin
              mul_start_nxt = 1'b1;
              mul_a_nxt     = ONE_Q24 - sus_q24;
              mul_b_nxt     = {1'b0, p_sat};
              op_nxt        = OP_DEC_E;
            end
            OP_DEC_E: begin
              env_nxt   = ONE_Q24 - p_shr24;
              state_nxt = S_RCHK;
            end
            OP_REL_R: begin
              if (r_full) begin
                env_nxt   = '0;
                state_nxt = S_GCHK;
              end else begin
                mul_start_nxt = 1'b1;
                mul_a_nxt     = env_r;
                mul_b_nxt     = {1'b0, one_minus_r};
                op_nxt        = OP_REL_E;
              end
            end
            OP_REL_E: begin
              env_nxt   = p_shr24;
              state_nxt = S_GCHK;
            end
            OP_GAIN: begin
              if (high_r) begin
                res_nxt = (mag > 16'h7FFF) ? 16'h7FFF : mag;
              end else begin
                res_nxt = 16'h0000 - mag;
              end
              state_nxt = S_OUT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // release ramp past the gate
      S_RCHK: begin
        if (rel_r) begin
          mul_start_nxt = 1'b1;
          mul_a_nxt     = release_rate_r;
          mul_b_nxt     = {5'b0, note_age_r - {1'b0, held_gate_r}};
          op_nxt        = OP_REL_R;
          state_nxt     = S_MUL;
        end else begin
          state_nxt = S_GCHK;
        end
      end

      // silent voice holds phase; otherwise advance and scale by gain
      S_GCHK: begin
        if (env_r == '0) begin
          res_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          osc_phase_nxt = phase_sum[23:0];
          if (NOISE_VOICE) begin
            if (phase_sum[24]) begin
              lfsr_nxt = lfsr_step;
              high_nxt = lfsr_step[0];
            end else begin
              high_nxt = lfsr_r[0];
            end
          end else begin
            high_nxt = {1'b0, phase_sum[23:0]} < {duty_sat, 8'b0};
          end
          mul_start_nxt = 1'b1;
          mul_a_nxt     = env_r;
          mul_b_nxt     = {9'b0, gain_sat};
          op_nxt        = OP_GAIN;
          state_nxt     = S_MUL;
        end
      end

      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_ATK;
      note_age_r  <= '0;
      osc_phase_r <= '0;
      lfsr_r      <= 16'h0001;
      held_step_r <= '0;
      held_gate_r <= '0;
      mul_start_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      note_age_r  <= note_age_nxt;
      osc_phase_r <= osc_phase_nxt;
      lfsr_r      <= lfsr_nxt;
      held_step_r <= held_step_nxt;
      held_gate_r <= held_gate_nxt;
      mul_start_r <= mul_start_nxt;
    end
  end

  // working values
  always_ff @(posedge clk) begin
    rel_r   <= rel_nxt;
    high_r  <= high_nxt;
    env_r   <= env_nxt;
    res_r   <= res_nxt;
    mul_a_r <= mul_a_nxt;
    mul_b_r <= mul_b_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_len_r    <= RST_ATTACK_LEN;
      attack_rate_r   <= RST_ATTACK_RATE;
      decay_len_r     <= RST_DECAY_LEN;
      decay_rate_r    <= RST_DECAY_RATE;
      sustain_level_r <= RST_SUSTAIN_LEVEL;
      release_rate_r  <= RST_RELEASE_RATE;
      pulse_duty_r    <= RST_PULSE_DUTY;
      output_gain_r   <= RST_OUTPUT_GAIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATTACK_LEN:    attack_len_r    <= cfg_wdata[19:0];
        REG_ATTACK_RATE:   attack_rate_r   <= cfg_wdata;
        REG_DECAY_LEN:     decay_len_r     <= cfg_wdata[19:0];
        REG_DECAY_RATE:    decay_rate_r    <= cfg_wdata;
        REG_SUSTAIN_LEVEL: sustain_level_r <= cfg_wdata[15:0];
        REG_RELEASE_RATE:  release_rate_r  <= cfg_wdata;
        REG_PULSE_DUTY:    pulse_duty_r    <= cfg_wdata[16:0];
        REG_OUTPUT_GAIN:   output_gain_r   <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= res_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // shared serial multiplier
  assign mreq.start = mul_start_r;
  assign mreq.a     = mul_a_r;
  assign mreq.b     = mul_b_r;

  pnv_smul u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

endmodule

[hw/rtl/pnv_checker.sv]
// pnv_checker: port-level checks on the voice unit over time, bound to
// pulse_noise_voice_adsr_unit; no package dependencies

module pnv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_sample_out
);

  // a stalled result holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out))
    else $error("result changed while stalled");

  // a note-on transfer with no result waiting creates no result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action && !out_valid |=> !out_valid)
    else $error("result appeared after note-on");

  // a tick transfer occupies the unit
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_action |=> !in_ready)
    else $error("input taken while a tick is in progress");

  // reset empties the result channel
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pulse_noise_voice_adsr_unit pnv_checker u_pnv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_action      (in_action),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_sample_out (out_sample_out)
);
